// File: hw/rtl/dse_pkg.sv
// ----------------------------------------------------------------------------
// dse_pkg
// Shared constants for the distinct set equality block.
// ----------------------------------------------------------------------------
package dse_pkg;

  localparam int unsigned DSE_DEPTH      = 1024;
  localparam int unsigned DSE_VALUE_BITS = 32;

  localparam logic DSE_LIST_FIRST  = 1'b0;
  localparam logic DSE_LIST_SECOND = 1'b1;

endpackage

// File: hw/rtl/distinct_set_equality_top.sv
// ----------------------------------------------------------------------------
// distinct_set_equality_top
// Compares the distinct values of two loaded lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an element transfer happens on a clock edge with start
//   high and busy low. in_list_id picks the list, in_last closes that list.
//   Elements for a closed list are ignored until the pair is answered.
//   Loading takes one element per cycle. Elements past DEPTH are dropped
//   and the overflow bit is reported with the result.
//   Once both lists are closed, busy rises and the block checks every stored
//   value of each list against the other list with one shared comparator
//   fed by one read port on each store. Each compare passes through S_SETUP
//   and S_CMP, each outer entry through one more S_SETUP step. A match ends
//   an inner scan early, and a miss ends the check.
//   The result is shown on out_equal / out_overflow for one cycle, marked
//   by out_valid; the receiver cannot stall it. In that same cycle busy is
//   already low and a new pair of lists may start loading.
//   Sync reset (rst_n low) empties both lists, clears all flags but results.
//   The stores need no clearing pass: only entries below the counts are read.
// ----------------------------------------------------------------------------
module distinct_set_equality_top
  import dse_pkg::*;
#(
  parameter int unsigned DEPTH = DSE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_list_id,
  input  logic signed [DSE_VALUE_BITS-1:0] in_value,
  input  logic                             in_last,
  output logic                             out_valid,
  output logic                             out_equal,
  output logic                             out_overflow
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {S_LOAD, S_SETUP, S_CMP} state_t;

  logic [DSE_VALUE_BITS-1:0] mem_a [DEPTH];
  logic [DSE_VALUE_BITS-1:0] mem_b [DEPTH];
  logic [DSE_VALUE_BITS-1:0] rd_a_r, rd_b_r;

  state_t        state_r;
  logic [CW-1:0] cnt_a_r, cnt_b_r, outer_r, inner_r;
  logic          done_a_r, done_b_r, lost_r, phase_r, found_r;
  logic          out_valid_r, out_equal_r, out_overflow_r;

  logic          accept, take, wr_a, wr_b, done_a_nxt, done_b_nxt;
  logic [CW-1:0] n_outer, n_inner;
  logic [AW-1:0] addr_a, addr_b;

  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;
  assign take   = accept && !((in_list_id == DSE_LIST_SECOND) ? done_b_r : done_a_r);
  assign wr_a   = take && (in_list_id == DSE_LIST_FIRST) && (cnt_a_r < DEPTH_C);
  assign wr_b   = take && (in_list_id == DSE_LIST_SECOND) && (cnt_b_r < DEPTH_C);
  assign done_a_nxt = done_a_r || (take && in_last && (in_list_id == DSE_LIST_FIRST));
  assign done_b_nxt = done_b_r || (take && in_last && (in_list_id == DSE_LIST_SECOND));

  // phase 0: each entry of A searched in B; phase 1: each entry of B in A
  assign n_outer = phase_r ? cnt_b_r : cnt_a_r;
  assign n_inner = phase_r ? cnt_a_r : cnt_b_r;
  assign addr_a  = busy ? (phase_r ? inner_r[AW-1:0] : outer_r[AW-1:0]) : cnt_a_r[AW-1:0];
  assign addr_b  = busy ? (phase_r ? outer_r[AW-1:0] : inner_r[AW-1:0]) : cnt_b_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[addr_a] <= in_value;
    end
    rd_a_r <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[addr_b] <= in_value;
    end
    rd_b_r <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      done_a_r    <= 1'b0;
      done_b_r    <= 1'b0;
      lost_r      <= 1'b0;
      phase_r     <= 1'b0;
      found_r     <= 1'b0;
      outer_r     <= '0;
      inner_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (take) begin
            if (wr_a) cnt_a_r <= cnt_a_r + 1'b1;
            if (wr_b) cnt_b_r <= cnt_b_r + 1'b1;
            if (!wr_a && !wr_b) lost_r <= 1'b1;
            done_a_r <= done_a_nxt;
            done_b_r <= done_b_nxt;
            if (done_a_nxt && done_b_nxt) begin
              state_r <= S_SETUP;
              phase_r <= 1'b0;
              outer_r <= '0;
              inner_r <= '0;
              found_r <= 1'b0;
            end
          end
        end
        S_SETUP: begin
          if (outer_r == n_outer) begin
            if (!phase_r) begin
              phase_r <= 1'b1;
              outer_r <= '0;
              inner_r <= '0;
              found_r <= 1'b0;
            end else begin
              out_valid_r    <= 1'b1;
              out_equal_r    <= 1'b1;
              out_overflow_r <= lost_r;
              state_r        <= S_LOAD;
              cnt_a_r <= '0;  cnt_b_r <= '0;
              done_a_r <= 1'b0; done_b_r <= 1'b0; lost_r <= 1'b0;
            end
          end else if (inner_r == n_inner) begin
            if (!found_r) begin
              out_valid_r    <= 1'b1;
              out_equal_r    <= 1'b0;
              out_overflow_r <= lost_r;
              state_r        <= S_LOAD;
              cnt_a_r <= '0;  cnt_b_r <= '0;
              done_a_r <= 1'b0; done_b_r <= 1'b0; lost_r <= 1'b0;
            end else begin
              outer_r <= outer_r + 1'b1;
              inner_r <= '0;
              found_r <= 1'b0;
            end
          end else begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // a match ends the inner scan early
          if (rd_a_r == rd_b_r) begin
            found_r <= 1'b1;
            inner_r <= n_inner;
          end else begin
            inner_r <= inner_r + 1'b1;
          end
          state_r <= S_SETUP;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_equal    = out_equal_r;
  assign out_overflow = out_overflow_r;

endmodule

// File: hw/rtl/dse_checker.sv
// ----------------------------------------------------------------------------
// dse_checker
// Port-level checks on the distinct set equality block.
// ----------------------------------------------------------------------------
module dse_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("out_valid held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy rose without a transfer");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy fell without a result");

endmodule

bind distinct_set_equality_top dse_checker u_dse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// File: verif/tb_distinct_set_equality_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_set_equality_top
// Self-checking bench for the distinct set equality block: directed pairs of
// lists with hand-written answers, one overflow pair, then random pairs
// checked against a set-based prediction. The sender gaps at random.
// ----------------------------------------------------------------------------
module tb_distinct_set_equality_top;
  import dse_pkg::*;

  typedef logic signed [DSE_VALUE_BITS-1:0] elem_t;
  typedef struct packed {
    logic equal;
    logic overflow;
  } verdict_t;
  typedef struct {
    logic  list_id;
    elem_t value;
    logic  last;
    logic  typed;
    logic  equal;
    logic  overflow;
  } row_t;

  localparam elem_t VMIN = {1'b1, {(DSE_VALUE_BITS-1){1'b0}}};
  localparam elem_t VMAX = {1'b0, {(DSE_VALUE_BITS-1){1'b1}}};

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  logic  in_list_id = DSE_LIST_FIRST;
  elem_t in_value = '0;
  logic  in_last = 1'b0;
  logic  out_valid;
  logic  out_equal;
  logic  out_overflow;

  distinct_set_equality_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_list_id(in_list_id), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_equal(out_equal), .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: loaded values per list, closed flags, dropped-element flag.
  elem_t    list_vals [2][$];
  logic     list_closed [2];
  logic     dropped;
  verdict_t verdicts_due [$];
  int       errors = 0;
  int       xfer_cnt = 0;
  logic     use_typed = 1'b0;
  verdict_t typed_verdict;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic same_distinct(input elem_t a[$], input elem_t b[$]);
    bit seen_a [elem_t];
    bit seen_b [elem_t];
    foreach (a[i]) seen_a[a[i]] = 1'b1;
    foreach (b[i]) seen_b[b[i]] = 1'b1;
    if (seen_a.num() != seen_b.num()) return 1'b0;
    foreach (seen_a[k]) if (!seen_b.exists(k)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_lists();
    list_vals[0].delete();
    list_vals[1].delete();
    list_closed[0] = 1'b0;
    list_closed[1] = 1'b0;
    dropped = 1'b0;
  endfunction

  // Advances the model by one accepted element; queues a verdict on pair close.
  task automatic absorb_element(input logic id, input elem_t v, input logic lst);
    verdict_t vd;
    if (list_closed[id]) return;
    if (list_vals[id].size() < DSE_DEPTH) list_vals[id].push_back(v);
    else dropped = 1'b1;
    if (lst) list_closed[id] = 1'b1;
    if (!(list_closed[0] && list_closed[1])) return;
    vd.equal = same_distinct(list_vals[0], list_vals[1]);
    vd.overflow = dropped;
    if (use_typed) begin
      if (vd != typed_verdict)
        report($sformatf("model disagrees with typed verdict %b vs %b", vd, typed_verdict));
      vd = typed_verdict;
    end
    verdicts_due.push_back(vd);
    clear_lists();
  endtask

  initial clear_lists();

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      absorb_element(in_list_id, in_value, in_last);
      xfer_cnt <= xfer_cnt + 1;
    end
    if (rst_n && out_valid) begin
      if (verdicts_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        verdict_t e;
        e = verdicts_due.pop_front();
        if (out_equal !== e.equal)
          report($sformatf("equal got %b exp %b", out_equal, e.equal));
        if (out_overflow !== e.overflow)
          report($sformatf("overflow got %b exp %b", out_overflow, e.overflow));
      end
    end
  end

  // Drive one element at a falling edge, hold until transferred, then gap.
  task automatic send_elem(input logic id, input elem_t v, input logic lst);
    int n0;
    int gap;
    in_list_id = id;
    in_value = v;
    in_last = lst;
    start = 1'b1;
    n0 = xfer_cnt;
    do @(negedge clk); while (xfer_cnt == n0);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic elem_t pick_value();
    case ($urandom_range(0, 9))
      0: return VMIN;
      1: return VMAX;
      2, 3: return elem_t'($urandom);
      default: return elem_t'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  task automatic random_pair();
    elem_t pool[$];
    elem_t la[$];
    elem_t lb[$];
    int k, na, nb, ia, ib;
    logic closed_a, closed_b, id;
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) pool.push_back(pick_value());
    na = $urandom_range(k, 8);
    nb = $urandom_range(k, 8);
    for (int i = 0; i < na; i++) la.push_back(i < k ? pool[i] : pool[$urandom_range(0, k-1)]);
    for (int i = 0; i < nb; i++) lb.push_back(i < k ? pool[i] : pool[$urandom_range(0, k-1)]);
    la.shuffle();
    lb.shuffle();
    if ($urandom_range(0, 2) == 0) begin
      // break the match: replace one entry or drop one
      if ($urandom_range(0, 1)) lb[$urandom_range(0, nb-1)] = pick_value();
      else if (na > 1) void'(la.pop_back());
    end
    ia = 0; ib = 0; closed_a = 0; closed_b = 0;
    while (!(closed_a && closed_b)) begin
      id = closed_a ? 1'b1 : closed_b ? 1'b0 : logic'($urandom_range(0, 1));
      if (id == DSE_LIST_FIRST) begin
        send_elem(DSE_LIST_FIRST, la[ia], ia == la.size() - 1);
        ia++;
        closed_a = (ia == la.size());
        if (closed_a && !closed_b && $urandom_range(0, 3) == 0)
          send_elem(DSE_LIST_FIRST, pick_value(), logic'($urandom_range(0, 1)));
      end else begin
        send_elem(DSE_LIST_SECOND, lb[ib], ib == lb.size() - 1);
        ib++;
        closed_b = (ib == lb.size());
        if (closed_b && !closed_a && $urandom_range(0, 3) == 0)
          send_elem(DSE_LIST_SECOND, pick_value(), logic'($urandom_range(0, 1)));
      end
    end
  endtask

  row_t dir_rows[$];

  task automatic add_row(input logic id, input elem_t v, input logic lst,
                         input logic t = 0, input logic eq = 0, input logic ov = 0);
    row_t r;
    r = '{id, v, lst, t, eq, ov};
    dir_rows.push_back(r);
  endtask

  initial begin
    int sent;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // extremes, one each
    add_row(DSE_LIST_FIRST, VMIN, 1);
    add_row(DSE_LIST_SECOND, VMAX, 1, 1, 0, 0);
    // both extremes in both lists, with a repeat
    add_row(DSE_LIST_FIRST, VMIN, 0);
    add_row(DSE_LIST_FIRST, VMAX, 1);
    add_row(DSE_LIST_SECOND, VMAX, 0);
    add_row(DSE_LIST_SECOND, VMIN, 0);
    add_row(DSE_LIST_SECOND, VMIN, 1, 1, 1, 0);
    // element for a closed list is ignored
    add_row(DSE_LIST_FIRST, 5, 1);
    add_row(DSE_LIST_FIRST, 9, 1);
    add_row(DSE_LIST_SECOND, 5, 1, 1, 1, 0);
    // duplicates on both sides
    add_row(DSE_LIST_FIRST, -1, 0);
    add_row(DSE_LIST_FIRST, -1, 0);
    add_row(DSE_LIST_FIRST, 2, 1);
    add_row(DSE_LIST_SECOND, 2, 0);
    add_row(DSE_LIST_SECOND, -1, 1, 1, 1, 0);
    // proper subset
    add_row(DSE_LIST_SECOND, 3, 0);
    add_row(DSE_LIST_SECOND, 4, 1);
    add_row(DSE_LIST_FIRST, 3, 1, 1, 0, 0);
    // unchecked by hand
    add_row(DSE_LIST_FIRST, 32'h5555_aaaa, 0);
    add_row(DSE_LIST_SECOND, 32'haaaa_5555, 1);
    add_row(DSE_LIST_FIRST, 32'haaaa_5555, 1);

    foreach (dir_rows[i]) begin
      use_typed = dir_rows[i].typed;
      typed_verdict = '{dir_rows[i].equal, dir_rows[i].overflow};
      send_elem(dir_rows[i].list_id, dir_rows[i].value, dir_rows[i].last);
    end
    use_typed = 1'b0;

    // hold off until the directed results are in
    start = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);

    // store full: DEPTH+1 elements, the last one dropped but still closing
    for (int i = 0; i <= DSE_DEPTH; i++) begin
      send_elem(DSE_LIST_FIRST, elem_t'(i % 4), i == DSE_DEPTH);
    end
    for (int i = 0; i < 4; i++) begin
      if (i == 3) begin
        use_typed = 1'b1;
        typed_verdict = '{1'b1, 1'b1};
      end
      send_elem(DSE_LIST_SECOND, elem_t'(3 - i), i == 3);
    end
    use_typed = 1'b0;

    sent = dir_rows.size() + DSE_DEPTH + 5;
    while (sent < 1900) begin
      int n0;
      n0 = xfer_cnt;
      random_pair();
      sent += xfer_cnt - n0;
    end

    start = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
